### rtl/pibx_pkg.sv
// Package for the lidar point image box assign block.
// Shared types, widths, function codes and state encoding. No dependencies.
`default_nettype none
package pibx_pkg;

    localparam int MAX_BOXES_DEF  = 16;
    localparam int PIXEL_BITS_DEF = 13;

    localparam int COEF_W = 32;              // Q16.16 coefficient / point coordinate
    localparam int CFG_W  = 64;              // two packed coefficients
    localparam int ACC_W  = 66;              // exact row sum, signed
    localparam int QW     = 42;              // clamped floor quotient, signed Q26.16
    localparam int HIT_W  = 16;
    localparam int HELD_W = 5;
    localparam int CIDX_W = 3;

    typedef logic signed [QW-1:0] t_q;

    typedef enum logic [1:0] {
        FN_CLEAR   = 2'd0,
        FN_APPEND  = 2'd1,
        FN_PROJECT = 2'd2,
        FN_NOP     = 2'd3
    } t_func;

    typedef enum logic [CIDX_W-1:0] {
        CFG_U01 = 3'd0,
        CFG_U23 = 3'd1,
        CFG_V01 = 3'd2,
        CFG_V23 = 3'd3,
        CFG_D01 = 3'd4,
        CFG_D23 = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_CHAIN,
        S_EMIT
    } t_state;

    // point token walking down the box cells
    typedef struct packed {
        logic             vld;
        t_q               qu;
        logic             fu;
        t_q               qv;
        logic             fv;
        logic [HIT_W-1:0] mask;
    } t_tok;

endpackage
`default_nettype wire

### rtl/pibx_div.sv
// Restoring bit-serial divider: floor(n * 2^16 / d) for d > 0, clamped to +-2^40.
// One quotient bit per cycle. Depends on pibx_pkg.
`default_nettype none
module pibx_div
    import pibx_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [ACC_W-1:0] i_num,
    input  wire logic        [ACC_W-1:0] i_den,
    output logic                         o_done,
    output t_q                           o_q,
    output logic                         o_frac
);
    localparam int NB    = ACC_W + 16;
    localparam int CNT_W = $clog2(NB + 1);
    localparam logic [NB:0] LIM = (NB+1)'(1) << 40;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NB-1:0]    r_num;
    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_den;
    logic             r_neg;

    logic [ACC_W-1:0] mag;
    logic [ACC_W:0]   sh;
    logic [ACC_W:0]   diff;
    logic             ge;
    logic [NB:0]      qa;
    logic             over;
    logic [QW-1:0]    magq;

    assign mag  = i_num[ACC_W-1] ? (~i_num + ACC_W'(1)) : i_num;
    assign sh   = {r_rem, r_num[NB-1]};
    assign diff = sh - {1'b0, r_den};
    assign ge   = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[ACC_W-1];
            r_num <= {mag, 16'h0};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[ACC_W-1:0] : sh[ACC_W-1:0];
            r_num <= {r_num[NB-2:0], ge};
        end
    end

    assign o_frac = |r_rem;
    assign qa     = {1'b0, r_num} + (NB+1)'(r_neg & o_frac);
    assign over   = (qa > LIM);
    assign magq   = over ? LIM[QW-1:0] : qa[QW-1:0];
    assign o_q    = r_neg ? t_q'(~magq + QW'(1)) : t_q'(magq);
    assign o_done = r_done;

endmodule
`default_nettype wire

### rtl/pibx_cell.sv
// One box cell: holds one stored box, tests the passing point token strictly
// against it and hands the token to the next cell. Depends on pibx_pkg.
`default_nettype none
module pibx_cell
    import pibx_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int IDX        = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_we,
    input  wire logic [4*PIXEL_BITS-1:0] i_box,
    input  wire logic                    i_active,
    input  wire t_tok                    i_tok,
    output t_tok                         o_tok
);
    logic [4*PIXEL_BITS-1:0] r_box;
    t_tok                    r_tok;
    t_tok                    n_tok;

    t_q  k_xmin, k_xmax, k_ymin, k_ymax;
    logic hit;

    assign k_xmin = t_q'({r_box[0*PIXEL_BITS +: PIXEL_BITS], 16'h0});
    assign k_xmax = t_q'({r_box[1*PIXEL_BITS +: PIXEL_BITS], 16'h0});
    assign k_ymin = t_q'({r_box[2*PIXEL_BITS +: PIXEL_BITS], 16'h0});
    assign k_ymax = t_q'({r_box[3*PIXEL_BITS +: PIXEL_BITS], 16'h0});

    always_comb begin
        hit = i_active
            && (i_tok.qu > k_xmin || (i_tok.qu == k_xmin && i_tok.fu))
            && (i_tok.qu < k_xmax)
            && (i_tok.qv > k_ymin || (i_tok.qv == k_ymin && i_tok.fv))
            && (i_tok.qv < k_ymax);
        n_tok      = i_tok;
        n_tok.mask = i_tok.mask | (HIT_W'(hit) << IDX);
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_box <= i_box;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.qu   <= n_tok.qu;
        r_tok.fu   <= n_tok.fu;
        r_tok.qv   <= n_tok.qv;
        r_tok.fv   <= n_tok.fv;
        r_tok.mask <= n_tok.mask;
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

### rtl/lidar_point_image_box_assign.sv
// Path: clear/append/no-op go straight to emit; project behind camera runs
// the products and depth check only; project in front goes on (9 serial products on one 32x32
// multiplier, 82-step bit-serial dividers for u and v side by side, then the box cell chain).
// Throughput: one item at a time; the next item is taken while a result waits on the output.
// Reset: synchronous active low; clears FSM, box count, coefficients and output valid.
// Depends on pibx_pkg, pibx_div, pibx_cell.
`default_nettype none
module lidar_point_image_box_assign
    import pibx_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int IN_W  = ((4*PIXEL_BITS + 3*COEF_W + 7) / 8) * 8,
    localparam int OUT_W = ((1 + 2*COEF_W + HIT_W + HELD_W + 1 + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // box_xmin, box_xmax, box_ymin, box_ymax, point_x, point_y, point_z
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // func
    input  wire logic [1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // in_front, pixel_u, pixel_v, hit_mask, boxes_held, box_dropped
    output logic [OUT_W-1:0]       m_axis_tdata
);
    localparam int CW   = $clog2(MAX_BOXES + 1);
    localparam int BW   = 4*PIXEL_BITS;
    localparam int PX   = BW;
    localparam int RW   = 1 + 2*COEF_W + HIT_W + HELD_W + 1;
    localparam t_q SMAX = t_q'(32'h7fff_ffff);
    localparam t_q SMIN = t_q'(~t_q'(32'h7fff_ffff));

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg [6];
    logic [CW-1:0]    r_count;
    logic signed [COEF_W-1:0] r_px, r_py, r_pz;

    logic [3:0]                r_step;
    logic signed [2*COEF_W-1:0] r_prod;
    logic [1:0]                r_pdst;
    logic                      r_pvld;
    logic signed [ACC_W-1:0]   r_acc [3];

    logic              r_res_front;
    logic [COEF_W-1:0] r_res_pu, r_res_pv;
    logic [HIT_W-1:0]  r_res_hit;
    logic              r_res_drop;

    logic             r_ovld;
    logic [RW-1:0]    r_odata;

    t_tok r_tok0;
    t_tok w_tok [MAX_BOXES+1];

    logic   accept;
    t_func  func;
    logic [BW-1:0] in_box;
    logic   append_ok;
    logic   front;
    logic   div_start;
    logic   du_done, dv_done;
    logic   div_done;
    t_q     du_q, dv_q;
    logic   du_frac, dv_frac;
    logic signed [COEF_W-1:0] m_a, m_b;
    logic [1:0] m_dst;
    logic   out_free;

    assign func      = t_func'(s_axis_tuser);
    assign in_box    = s_axis_tdata[0 +: BW];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign append_ok = (r_count < CW'(MAX_BOXES));
    assign front     = !r_acc[2][ACC_W-1] && (r_acc[2] != '0);
    assign out_free  = !r_ovld || m_axis_tready;
    assign div_start = (r_state == S_CHK) && front;
    assign div_done  = du_done && dv_done;

    function automatic logic [COEF_W-1:0] sat32(input t_q q);
        if (q > SMAX) begin
            return SMAX[COEF_W-1:0];
        end else if (q < SMIN) begin
            return SMIN[COEF_W-1:0];
        end
        return q[COEF_W-1:0];
    endfunction

    // product schedule: rows u, v, depth; terms x, y, z
    always_comb begin
        m_a   = '0;
        m_b   = '0;
        m_dst = 2'd0;
        unique case (r_step)
            4'd0: begin m_a = r_cfg[CFG_U01][31:0];  m_b = r_px; m_dst = 2'd0; end
            4'd1: begin m_a = r_cfg[CFG_U01][63:32]; m_b = r_py; m_dst = 2'd0; end
            4'd2: begin m_a = r_cfg[CFG_U23][31:0];  m_b = r_pz; m_dst = 2'd0; end
            4'd3: begin m_a = r_cfg[CFG_V01][31:0];  m_b = r_px; m_dst = 2'd1; end
            4'd4: begin m_a = r_cfg[CFG_V01][63:32]; m_b = r_py; m_dst = 2'd1; end
            4'd5: begin m_a = r_cfg[CFG_V23][31:0];  m_b = r_pz; m_dst = 2'd1; end
            4'd6: begin m_a = r_cfg[CFG_D01][31:0];  m_b = r_px; m_dst = 2'd2; end
            4'd7: begin m_a = r_cfg[CFG_D01][63:32]; m_b = r_py; m_dst = 2'd2; end
            4'd8: begin m_a = r_cfg[CFG_D23][31:0];  m_b = r_pz; m_dst = 2'd2; end
            default: begin m_a = '0; m_b = '0; m_dst = 2'd0; end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (func == FN_PROJECT) ? S_MUL : S_EMIT;
                end
            end
            S_MUL: begin
                if (r_step == 4'd9) begin
                    n_state = S_CHK;
                end
            end
            S_CHK:   n_state = front ? S_DIV : S_EMIT;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_CHAIN;
                end
            end
            S_CHAIN: begin
                if (w_tok[MAX_BOXES].vld) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_cfg[i] <= '0;
            end
            r_count    <= '0;
            r_ovld     <= 1'b0;
            r_tok0.vld <= 1'b0;
            r_pvld     <= 1'b0;
            r_step     <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx <= CFG_D23) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (accept && func == FN_CLEAR) begin
                r_count <= '0;
            end else if (accept && func == FN_APPEND && append_ok) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == S_EMIT && out_free) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            r_tok0.vld <= (r_state == S_DIV) && div_done;
            if (r_state == S_DIV && div_done) begin
                r_tok0.qu   <= du_q;
                r_tok0.fu   <= du_frac;
                r_tok0.qv   <= dv_q;
                r_tok0.fv   <= dv_frac;
                r_tok0.mask <= '0;
            end
            r_pvld     <= (r_state == S_MUL) && (r_step < 4'd9);
            if (accept) begin
                r_step <= '0;
            end else if (r_state == S_MUL) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px        <= s_axis_tdata[PX +: COEF_W];
            r_py        <= s_axis_tdata[PX + COEF_W +: COEF_W];
            r_pz        <= s_axis_tdata[PX + 2*COEF_W +: COEF_W];
            r_acc[0]    <= {{(ACC_W-COEF_W-16){r_cfg[CFG_U23][63]}}, r_cfg[CFG_U23][63:32], 16'h0};
            r_acc[1]    <= {{(ACC_W-COEF_W-16){r_cfg[CFG_V23][63]}}, r_cfg[CFG_V23][63:32], 16'h0};
            r_acc[2]    <= {{(ACC_W-COEF_W-16){r_cfg[CFG_D23][63]}}, r_cfg[CFG_D23][63:32], 16'h0};
            r_res_front <= 1'b0;
            r_res_pu    <= '0;
            r_res_pv    <= '0;
            r_res_hit   <= '0;
            r_res_drop  <= (func == FN_APPEND) && !append_ok;
        end else if (r_pvld) begin
            r_acc[r_pdst] <= r_acc[r_pdst] + {{(ACC_W-2*COEF_W){r_prod[2*COEF_W-1]}}, r_prod};
        end
        r_prod <= m_a * m_b;
        r_pdst <= m_dst;
        if (r_state == S_DIV && div_done) begin
            r_res_front <= 1'b1;
            r_res_pu    <= sat32(du_q);
            r_res_pv    <= sat32(dv_q);
        end
        if (r_state == S_CHAIN && w_tok[MAX_BOXES].vld) begin
            r_res_hit <= w_tok[MAX_BOXES].mask;
        end
        if (r_state == S_EMIT && out_free) begin
            r_odata <= {r_res_drop, HELD_W'(r_count), r_res_hit,
                        r_res_pv, r_res_pu, r_res_front};
        end
    end

    pibx_div u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc[0]),
        .i_den   (r_acc[2]),
        .o_done  (du_done),
        .o_q     (du_q),
        .o_frac  (du_frac)
    );

    pibx_div u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc[1]),
        .i_den   (r_acc[2]),
        .o_done  (dv_done),
        .o_q     (dv_q),
        .o_frac  (dv_frac)
    );

    assign w_tok[0] = r_tok0;

    for (genvar j = 0; j < MAX_BOXES; j++) begin : g_cell
        pibx_cell #(
            .PIXEL_BITS (PIXEL_BITS),
            .IDX        (j)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_we     (accept && func == FN_APPEND && r_count == CW'(j)),
            .i_box    (in_box),
            .i_active (r_count > CW'(j)),
            .i_tok    (w_tok[j]),
            .o_tok    (w_tok[j+1])
        );
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {{(OUT_W-RW){1'b0}}, r_odata};

endmodule
`default_nettype wire

### rtl/pibx_chk.sv
// Port-level checker for lidar_point_image_box_assign, bound to the top level.
// Depends on pibx_pkg.
`default_nettype none
module pibx_chk
    import pibx_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int IN_W  = ((4*PIXEL_BITS + 3*COEF_W + 7) / 8) * 8,
    localparam int OUT_W = ((1 + 2*COEF_W + HIT_W + HELD_W + 1 + 7) / 8) * 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_cfg_we,
    input wire logic [CIDX_W-1:0] i_cfg_idx,
    input wire logic [CFG_W-1:0]  i_cfg_data,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [IN_W-1:0]   s_axis_tdata,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_W-1:0]  m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |->
        m_axis_tdata[80:1] == '0)
        else $error("point not in front carries nonzero pixel or hits");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[86] |->
        m_axis_tdata[85:81] == HELD_W'(MAX_BOXES))
        else $error("box dropped while table not full");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in flight");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind lidar_point_image_box_assign pibx_chk #(
    .MAX_BOXES  (MAX_BOXES),
    .PIXEL_BITS (PIXEL_BITS)
) u_pibx_chk (.*);
`default_nettype wire
